### hw/rtl/vipf_pkg.sv
package vipf_pkg;

  typedef enum logic [2:0] {
    PH_ETH  = 3'd0,
    PH_VLAN = 3'd1,
    PH_IP4  = 3'd2,
    PH_IP6  = 3'd3,
    PH_ICMP = 3'd4,
    PH_DONE = 3'd5
  } phase_t;

  localparam int unsigned OFF_W    = 7;
  localparam int unsigned TAG_CNT_W = 4;

  localparam logic [15:0] TYPE_VLAN = 16'h8100;
  localparam logic [15:0] TYPE_IP4  = 16'h0800;
  localparam logic [15:0] TYPE_IP6  = 16'h86DD;

  localparam logic [7:0] PROTO_ICMP4 = 8'd1;
  localparam logic [7:0] PROTO_ICMP6 = 8'd58;

  // byte offsets inside each header
  localparam logic [OFF_W-1:0] ETH_TYPE_HI  = 7'd12;
  localparam logic [OFF_W-1:0] ETH_TYPE_LO  = 7'd13;
  localparam logic [OFF_W-1:0] VLAN_TYPE_HI = 7'd2;
  localparam logic [OFF_W-1:0] VLAN_TYPE_LO = 7'd3;
  localparam logic [OFF_W-1:0] IP4_PROTO    = 7'd9;
  localparam logic [OFF_W-1:0] IP4_END      = 7'd19;
  localparam logic [OFF_W-1:0] IP6_NXT_HDR  = 7'd6;
  localparam logic [OFF_W-1:0] IP6_END      = 7'd39;
  localparam logic [OFF_W-1:0] ICMP_SEQ_HI  = 7'd6;
  localparam logic [OFF_W-1:0] ICMP_SEQ_LO  = 7'd7;

  typedef struct packed {
    logic       step;
    logic [7:0] data;
    logic       last;
  } parse_in_t;

endpackage

### hw/rtl/vipf_parser.sv
module vipf_parser #(
  parameter int unsigned VLAN_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vipf_pkg::parse_in_t pin,
  output logic               verdict
);
  import vipf_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [OFF_W-1:0]       off_r, off_nxt;
  logic [7:0]             type_hi_r, type_hi_nxt;
  logic [TAG_CNT_W-1:0]   tag_cnt_r, tag_cnt_nxt;
  logic                   is_ipv6_r, is_ipv6_nxt;
  logic                   drop_pend_r, drop_pend_nxt;
  logic [15:0]            type_full;
  logic                   drop_set;

  assign type_full = {type_hi_r, pin.data};

  // next-state logic for one byte
  always_comb begin
    phase_nxt     = phase_r;
    off_nxt       = off_r + 1'b1;
    type_hi_nxt   = type_hi_r;
    tag_cnt_nxt   = tag_cnt_r;
    is_ipv6_nxt   = is_ipv6_r;
    drop_set      = 1'b0;
    case (phase_r)
      PH_ETH, PH_VLAN: begin
        if (off_r == ((phase_r == PH_ETH) ? ETH_TYPE_HI : VLAN_TYPE_HI)) begin
          type_hi_nxt = pin.data;
        end else if (off_r == ((phase_r == PH_ETH) ? ETH_TYPE_LO : VLAN_TYPE_LO)) begin
          off_nxt = '0;
          if (type_full == TYPE_VLAN &&
              tag_cnt_r < TAG_CNT_W'(VLAN_DEPTH)) begin
            tag_cnt_nxt = tag_cnt_r + 1'b1;
            phase_nxt   = PH_VLAN;
          end else if (type_full == TYPE_IP4) begin
            phase_nxt = PH_IP4;
          end else if (type_full == TYPE_IP6) begin
            is_ipv6_nxt = 1'b1;
            phase_nxt   = PH_IP6;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
      PH_IP4: begin
        if (off_r == IP4_PROTO && pin.data != PROTO_ICMP4) begin
          phase_nxt = PH_DONE;
        end else if (off_r == IP4_END) begin
          phase_nxt = PH_ICMP;
          off_nxt   = '0;
        end
      end
      PH_IP6: begin
        if (off_r == IP6_NXT_HDR && pin.data != PROTO_ICMP6) begin
          phase_nxt = PH_DONE;
        end else if (off_r == IP6_END) begin
          phase_nxt = PH_ICMP;
          off_nxt   = '0;
        end
      end
      PH_ICMP: begin
        if (off_r == ICMP_SEQ_HI) begin
          type_hi_nxt = pin.data;
        end else if (off_r == ICMP_SEQ_LO) begin
          // sequence parity is the low bit of its second byte
          drop_set  = ~pin.data[0];
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        off_nxt = '0;
      end
    endcase
    drop_pend_nxt = drop_pend_r | drop_set;
  end

  assign verdict = drop_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (pin.step && pin.last)) begin
      phase_r     <= PH_ETH;
      off_r       <= '0;
      type_hi_r   <= '0;
      tag_cnt_r   <= '0;
      is_ipv6_r   <= 1'b0;
      drop_pend_r <= 1'b0;
    end else if (pin.step) begin
      phase_r     <= phase_nxt;
      off_r       <= off_nxt;
      type_hi_r   <= type_hi_nxt;
      tag_cnt_r   <= tag_cnt_nxt;
      is_ipv6_r   <= is_ipv6_nxt;
      drop_pend_r <= drop_pend_nxt;
    end
  end

endmodule

### hw/rtl/vlan_ip_icmp_parity_filter_unit.sv
// Channel  | Direction | Ports                              | Meaning
// ---------+-----------+------------------------------------+------------------------------
// in       | input     | in_valid in_ready in_data_byte     | one frame byte per transfer,
//          |           | in_last_byte                       | last byte flagged
// out      | output    | out_valid out_ready out_drop       | one verdict per frame
//
// One byte per clock sustained while no verdict stalls: the byte sits in the
// input register while the parser updates its header state, verdict goes to the
// output register. out_valid rises once the last byte has left the input
// register and its verdict has been loaded into the output register.
// Reset (rst_n low, synchronous) returns parser and both registers to empty.
// A stalled verdict holds only a last byte in the input register; other
// bytes keep flowing.
module vlan_ip_icmp_parity_filter_unit #(
  parameter int unsigned VLAN_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_drop
);
  import vipf_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_data_r;
  logic       in_last_r;
  logic       out_vld_r;
  logic       out_drop_r;
  logic       consume;
  logic       verdict;
  parse_in_t  pin;

  assign consume  = in_vld_r && (!in_last_r || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || consume;

  assign pin.step = consume;
  assign pin.data = in_data_r;
  assign pin.last = in_last_r;

  vipf_parser #(
    .VLAN_DEPTH(VLAN_DEPTH)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .pin     (pin),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (consume && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last_r) begin
      out_drop_r <= verdict;
    end
  end

  assign out_valid = out_vld_r;
  assign out_drop  = out_drop_r;

endmodule
